### rtl/ps2hl_pkg.sv
// ----------------------------------------------------------------------------
// ps2hl_pkg
// Types and constants shared by the PS/2 host link core and its step logic.
// ----------------------------------------------------------------------------
package ps2hl_pkg;

	typedef enum logic [1:0] {
		KIND_FALL = 2'd0,
		KIND_RISE = 2'd1,
		KIND_SEND = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	localparam logic [3:0]        FRAME_EDGES     = 4'd11;
	localparam logic [3:0]        RX_SHIFT_LOW    = 4'd2;
	localparam logic signed [4:0] TX_PHASE_START  = 5'sd10;
	localparam logic signed [4:0] TX_PHASE_PARITY = 5'sd2;
	localparam logic signed [4:0] TX_PHASE_STOP   = 5'sd1;
	localparam logic signed [4:0] TX_PHASE_ACK    = 5'sd0;
	localparam logic signed [4:0] TX_PHASE_IDLE   = -5'sd1;
	localparam logic [15:0]       TIMEOUT_RESET   = 16'hffff;

	typedef struct packed {
		kind_t      kind;
		logic       data_line;
		logic [7:0] cmd_byte;
		logic       cmd_parity;
	} item_t;

	typedef struct packed {
		logic [7:0]        rx_shift;
		logic [3:0]        rx_bits_left;
		logic [7:0]        tx_shift;
		logic              tx_parity_bit;
		logic signed [4:0] tx_phase;
		logic              tx_active;
		logic [15:0]       idle_counter;
		logic              data_level;
	} state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       data_release;
		logic       request_to_send;
		logic       abort_pulse;
		logic       tx_busy;
		logic       tx_acked;
	} result_t;

endpackage

### rtl/ps2hl_step.sv
// ----------------------------------------------------------------------------
// ps2hl_step
// Next-state and result logic for one link event: receive framing, transmit
// sequencing and idle timeout.
// ----------------------------------------------------------------------------
module ps2hl_step (
	input  ps2hl_pkg::item_t   item,
	input  ps2hl_pkg::state_t  st,
	input  logic [15:0]        idle_timeout,
	output ps2hl_pkg::state_t  nx,
	output ps2hl_pkg::result_t res
);
	import ps2hl_pkg::*;

	always_comb begin
		nx = st;
		res = '0;
		if (item.kind == KIND_FALL || item.kind == KIND_RISE) begin
			nx.idle_counter = idle_timeout;
		end
		unique case (item.kind)
			KIND_FALL: begin
				if (st.tx_active) begin
					priority if (st.tx_phase > TX_PHASE_PARITY) begin
						nx.data_level = st.tx_shift[0];
						nx.tx_shift = {1'b0, st.tx_shift[7:1]};
						nx.tx_phase = st.tx_phase - 5'sd1;
					end else if (st.tx_phase == TX_PHASE_PARITY) begin
						nx.data_level = st.tx_parity_bit;
						nx.tx_phase = st.tx_phase - 5'sd1;
					end else if (st.tx_phase == TX_PHASE_STOP) begin
						nx.data_level = 1'b1;
						nx.tx_phase = st.tx_phase - 5'sd1;
					end else if (st.tx_phase == TX_PHASE_ACK) begin
						if (!item.data_line) begin
							nx.tx_active = 1'b0;
							nx.rx_bits_left = FRAME_EDGES;
							nx.tx_phase = TX_PHASE_IDLE;
							res.tx_acked = 1'b1;
						end
					end else begin
						nx.tx_phase = st.tx_phase;
					end
				end else begin
					if (st.rx_bits_left < FRAME_EDGES && st.rx_bits_left > RX_SHIFT_LOW) begin
						nx.rx_shift = {item.data_line, st.rx_shift[7:1]};
					end
					nx.rx_bits_left = st.rx_bits_left - 4'd1;
				end
			end
			KIND_RISE: begin
				if (!st.tx_active && st.rx_bits_left == 4'd0) begin
					res.rx_valid = 1'b1;
					res.rx_byte = st.rx_shift;
					nx.rx_bits_left = FRAME_EDGES;
					if (st.tx_phase > TX_PHASE_ACK) begin
						nx.data_level = 1'b0;
						nx.tx_active = 1'b1;
						res.request_to_send = 1'b1;
					end
				end
			end
			KIND_SEND: begin
				nx.tx_shift = item.cmd_byte;
				nx.tx_parity_bit = item.cmd_parity;
				nx.tx_phase = TX_PHASE_START;
				nx.data_level = 1'b0;
				nx.tx_active = 1'b1;
				res.request_to_send = 1'b1;
			end
			KIND_TICK: begin
				if (st.idle_counter <= 16'd1) begin
					if (st.tx_active) begin
						res.abort_pulse = 1'b1;
						nx.tx_active = 1'b0;
						nx.data_level = 1'b1;
					end
					nx.tx_phase = TX_PHASE_IDLE;
					nx.rx_bits_left = FRAME_EDGES;
					nx.idle_counter = idle_timeout;
				end else begin
					nx.idle_counter = st.idle_counter - 16'd1;
				end
			end
			default: begin
				nx = st;
			end
		endcase
		res.data_release = nx.data_level;
		res.tx_busy = nx.tx_active;
	end

endmodule

### rtl/ps2hl_core_top.sv
// ----------------------------------------------------------------------------
// ps2_host_link_core
// Host side of a PS/2 keyboard link driven by clock-edge, send and tick
// events, one result beat per event.
// ----------------------------------------------------------------------------
// Every event beat yields exactly one result beat. An event is held in an
// input register, then the link state and the result register are updated
// from it, so the core takes one event per clock while the result side is
// not stalled; the single state update loop through the step logic allows no
// more than one event per clock. A stalled result beat holds the input
// register, so at most two events are in flight.
module ps2_host_link_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // idle_timeout_ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // data_line, cmd_byte[8:1], cmd_parity, zero pad
	input  logic [1:0]  s_tuser,       // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata        // rx_byte[7:0], rx_valid, data_release,
	                                   // request_to_send, abort_pulse, tx_busy,
	                                   // tx_acked, zero pad
);
	import ps2hl_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	state_t      state_q;
	state_t      state_nx;
	result_t     res_nx;
	result_t     res_s2;
	logic        valid_s2;
	logic [15:0] idle_timeout_q;
	logic        advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			idle_timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= kind_t'(s_tuser);
			item_s1.data_line  <= s_tdata[0];
			item_s1.cmd_byte   <= s_tdata[8:1];
			item_s1.cmd_parity <= s_tdata[9];
		end
	end

	ps2hl_step u_step (
		.item         (item_s1),
		.st           (state_q),
		.idle_timeout (idle_timeout_q),
		.nx           (state_nx),
		.res          (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rx_shift      <= 8'd0;
			state_q.rx_bits_left  <= FRAME_EDGES;
			state_q.tx_shift      <= 8'd0;
			state_q.tx_parity_bit <= 1'b0;
			state_q.tx_phase      <= TX_PHASE_IDLE;
			state_q.tx_active     <= 1'b0;
			state_q.idle_counter  <= TIMEOUT_RESET;
			state_q.data_level    <= 1'b1;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.tx_acked, res_s2.tx_busy, res_s2.abort_pulse,
	                   res_s2.request_to_send, res_s2.data_release, res_s2.rx_valid,
	                   res_s2.rx_byte};

	// transmit phase stays within idle .. start
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.tx_phase >= TX_PHASE_IDLE) && (state_q.tx_phase <= TX_PHASE_START))
		else $error("tx phase out of range");

	// an abort ends the transmit and releases the data line
	a_abort_release: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.abort_pulse) |-> (!res_s2.tx_busy && res_s2.data_release))
		else $error("abort beat without release");

	// a request to send starts a transmit with the start bit driven low
	a_rts_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.request_to_send) |-> (res_s2.tx_busy && !res_s2.data_release))
		else $error("request to send without active transmit");

	// an acknowledge closes the transmit
	a_ack_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.tx_acked) |-> !res_s2.tx_busy)
		else $error("acknowledge with transmit still busy");

	// state only moves when an event is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("link state changed without an event");

endmodule
